[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros included by gip_result_merge.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[design/gip_pkg.sv]
// ---------------------------------------------------------------------------
// gip_pkg
// Types, constants and helpers of the gamepad input qualifier.
// ---------------------------------------------------------------------------
package gip_pkg;

    localparam int BUTTON_BITS     = 16;
    localparam int PAD_COUNT_DEF   = 4;
    localparam int CNT_W           = 11;
    localparam int LEVEL_W         = 16;
    localparam int AXIS_W          = 16;
    localparam int POS_W           = 15;
    localparam int AXES            = 4;
    localparam int SKIP_BIT_A      = 10;
    localparam int SKIP_BIT_B      = 11;
    localparam int USED_BUTTONS    = BUTTON_BITS - (SKIP_BIT_B - SKIP_BIT_A + 1);
    localparam int RESULTS         = USED_BUTTONS + AXES;
    localparam int HOLD_WRAP_AT    = 1000;
    localparam int HOLD_WRAP_TO    = 2;
    localparam int SLOT_W          = 4;
    localparam int CFG_INDEX_W     = 4;
    localparam int CFG_DATA_W      = 16;

    localparam logic ITEM_BUTTON = 1'b0;
    localparam logic ITEM_AXIS   = 1'b1;

    typedef logic signed [CNT_W-1:0]   count_t;
    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef logic signed [AXIS_W-1:0]  axis_t;
    typedef logic [POS_W-1:0]          pos_zone_t;
    typedef logic [BUTTON_BITS-1:0][CNT_W-1:0] row_t;

    localparam count_t HOLD_RELEASED = '1;

    localparam pos_zone_t LEFT_POS_RST  = 15'd7849;
    localparam axis_t     LEFT_NEG_RST  = -16'sd7849;
    localparam pos_zone_t RIGHT_POS_RST = 15'd8689;
    localparam axis_t     RIGHT_NEG_RST = -16'sd8689;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LX_POS = 4'd0,
        REG_LX_NEG = 4'd1,
        REG_LY_POS = 4'd2,
        REG_LY_NEG = 4'd3,
        REG_RX_POS = 4'd4,
        REG_RX_NEG = 4'd5,
        REG_RY_POS = 4'd6,
        REG_RY_NEG = 4'd7
    } reg_index_t;

    // One result word as it travels from the lanes into the merger.
    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        level_t            level;
    } result_t;

    // Button bit reported at position k of the button run.
    function automatic int button_of(input int k);
        return (k < SKIP_BIT_A) ? k : k + (SKIP_BIT_B - SKIP_BIT_A + 1);
    endfunction

endpackage

[design/gip_button_lane.sv]
// ---------------------------------------------------------------------------
// gip_button_lane
// Hold counter update of one button.
// ---------------------------------------------------------------------------
module gip_button_lane
    import gip_pkg::*;
(
    input  count_t old_count,
    input  logic   pressed,
    output count_t new_count
);

    logic signed [CNT_W:0] inc;

    assign inc = {old_count[CNT_W-1], old_count} + (CNT_W+1)'(1);

    always_comb
    begin
        if (pressed)
        begin
            if (inc >= HOLD_WRAP_AT)
                new_count = CNT_W'(HOLD_WRAP_TO);
            else
                new_count = inc[CNT_W-1:0];
        end
        else if (old_count > 0)
            new_count = HOLD_RELEASED;
        else
            new_count = '0;
    end

endmodule

[design/gip_axis_lane.sv]
// ---------------------------------------------------------------------------
// gip_axis_lane
// Asymmetric dead zone removal on one stick axis.
// ---------------------------------------------------------------------------
module gip_axis_lane
    import gip_pkg::*;
(
    input  axis_t     value,
    input  pos_zone_t pos_zone,
    input  axis_t     neg_zone,
    output level_t    level
);

    logic signed [AXIS_W+1:0] v_w;
    logic signed [AXIS_W+1:0] pos_w;
    logic signed [AXIS_W+1:0] neg_w;
    logic signed [AXIS_W+1:0] diff;
    logic                     outside;

    assign v_w     = {{2{value[AXIS_W-1]}}, value};
    assign pos_w   = {{(AXIS_W+2-POS_W){1'b0}}, pos_zone};
    assign neg_w   = {{2{neg_zone[AXIS_W-1]}}, neg_zone};
    assign outside = (v_w > pos_w) || (v_w < neg_w);
    assign diff    = (value > 0) ? (v_w - pos_w) : (v_w - neg_w);

    // A negative threshold set positive can push the difference out of range.
    always_comb
    begin
        if (!outside)
            level = '0;
        else if (diff > 18'sd32767)
            level = 16'sh7fff;
        else if (diff < -18'sd32768)
            level = 16'sh8000;
        else
            level = diff[LEVEL_W-1:0];
    end

endmodule

[design/gip_result_merge.sv]
// ---------------------------------------------------------------------------
// gip_result_merge
// Collects the lane results of one sample and sends them out one word a cycle while out_ready is high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gip_result_merge
    import gip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  result_t           words [RESULTS],
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              item_kind,
    output logic [SLOT_W-1:0] slot,
    output level_t            level,
    output logic              last_of_run
);

    localparam int LEFT_W = $clog2(RESULTS + 1);

    result_t             shift_reg [RESULTS];
    logic [LEFT_W-1:0]   left_reg;
    logic                take;

    assign out_valid   = (left_reg != '0);
    assign take        = out_valid && out_ready;
    assign last_of_run = (left_reg == LEFT_W'(1));
    assign can_load    = !out_valid || (last_of_run && out_ready);
    assign item_kind   = shift_reg[0].kind;
    assign slot        = shift_reg[0].slot;
    assign level       = shift_reg[0].level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else if (load)
            left_reg <= LEFT_W'(RESULTS);
        else if (take)
            left_reg <= left_reg - LEFT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (load)
            shift_reg <= words;
        else if (take)
        begin
            for (int i = 0; i < RESULTS - 1; i++)
                shift_reg[i] <= shift_reg[i + 1];
        end
    end

    `ASSERT_IMPL(a_last_is_ry, clk, rst_n, out_valid && last_of_run, item_kind == ITEM_AXIS && slot == SLOT_W'(AXES - 1), "last word is not the RY axis")
    `ASSERT_NEXT(a_load_full, clk, rst_n, load, left_reg == LEFT_W'(RESULTS), "run length wrong after load")
    `ASSERT_NEXT(a_run_unbroken, clk, rst_n, take && !last_of_run, out_valid, "run broken before its last word")

endmodule

[design/gamepad_input_qualifier.sv]
// ---------------------------------------------------------------------------
// gamepad_input_qualifier
// Button hold counters and stick dead zones for polled game pad samples.
// ---------------------------------------------------------------------------
// With the merger idle, an accepted sample is held in the sample register and
// is then loaded into the merger, whose first word is offered once it is loaded.
// A sample gives 18 result words, sent from the merger one word a cycle while out_ready is high.
// The next sample is accepted while the current run is still being sent.
// Reset clears all hold counters at once through per-pad row valid bits,
// restores the dead zone registers to their defaults and drops any run.
module gamepad_input_qualifier
    import gip_pkg::*;
#(
    parameter int PAD_COUNT = PAD_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             pad_index,
    input  logic [BUTTON_BITS-1:0] pressed_mask,
    input  axis_t                  left_x,
    input  axis_t                  left_y,
    input  axis_t                  right_x,
    input  axis_t                  right_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   item_kind,
    output logic [SLOT_W-1:0]      slot,
    output level_t                 level,
    output logic                   last_of_run
);

    localparam int ADDR_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    pos_zone_t              pos_zone_reg [AXES];
    axis_t                  neg_zone_reg [AXES];

    row_t                   hold_mem [PAD_COUNT];
    logic [PAD_COUNT-1:0]   row_valid_reg;
    row_t                   row_rdata_reg;

    logic                   s1_valid_reg;
    logic                   s1_ok_reg;
    logic                   s1_live_reg;
    logic [ADDR_W-1:0]      s1_addr_reg;
    logic [BUTTON_BITS-1:0] s1_mask_reg;
    axis_t                  s1_axis_reg [AXES];

    logic [ADDR_W+1:0]      pad_wide;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   rd_ok;
    logic                   accept;
    logic                   can_load;
    logic                   xfer;
    logic                   wr_en;
    logic                   same_row;
    row_t                   wr_row;
    result_t                words [RESULTS];
    level_t                 axis_level [AXES];

    assign pad_wide = {{ADDR_W{1'b0}}, pad_index};
    assign rd_addr  = pad_wide[ADDR_W-1:0];
    assign rd_ok    = (32'(pad_index) < PAD_COUNT);
    assign xfer     = s1_valid_reg && can_load;
    assign in_ready = !s1_valid_reg || can_load;
    assign accept   = in_valid && in_ready;
    assign wr_en    = xfer && s1_ok_reg;
    assign same_row = wr_en && (s1_addr_reg == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            row_valid_reg <= '0;
            pos_zone_reg[0] <= LEFT_POS_RST;
            neg_zone_reg[0] <= LEFT_NEG_RST;
            pos_zone_reg[1] <= LEFT_POS_RST;
            neg_zone_reg[1] <= LEFT_NEG_RST;
            pos_zone_reg[2] <= RIGHT_POS_RST;
            neg_zone_reg[2] <= RIGHT_NEG_RST;
            pos_zone_reg[3] <= RIGHT_POS_RST;
            neg_zone_reg[3] <= RIGHT_NEG_RST;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (xfer)
                s1_valid_reg <= 1'b0;
            if (wr_en)
                row_valid_reg[s1_addr_reg] <= 1'b1;
            if (cfg_write)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_LX_POS: pos_zone_reg[0] <= cfg_data[POS_W-1:0];
                    REG_LX_NEG: neg_zone_reg[0] <= cfg_data;
                    REG_LY_POS: pos_zone_reg[1] <= cfg_data[POS_W-1:0];
                    REG_LY_NEG: neg_zone_reg[1] <= cfg_data;
                    REG_RX_POS: pos_zone_reg[2] <= cfg_data[POS_W-1:0];
                    REG_RX_NEG: neg_zone_reg[2] <= cfg_data;
                    REG_RY_POS: pos_zone_reg[3] <= cfg_data[POS_W-1:0];
                    REG_RY_NEG: neg_zone_reg[3] <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // The sample register; the row read is write-first so that a sample of the
    // same pad entering as the previous one leaves sees the fresh counters.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg      <= rd_ok;
            s1_live_reg    <= rd_ok && (row_valid_reg[rd_addr] || same_row);
            s1_addr_reg    <= rd_addr;
            s1_mask_reg    <= pressed_mask;
            s1_axis_reg[0] <= left_x;
            s1_axis_reg[1] <= left_y;
            s1_axis_reg[2] <= right_x;
            s1_axis_reg[3] <= right_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            hold_mem[s1_addr_reg] <= wr_row;
        if (accept && rd_ok)
        begin
            if (same_row)
                row_rdata_reg <= wr_row;
            else
                row_rdata_reg <= hold_mem[rd_addr];
        end
    end

    generate
        for (genvar b = 0; b < BUTTON_BITS; b++)
        begin : g_unused
            if (b == SKIP_BIT_A || b == SKIP_BIT_B)
            begin : g_skip
                assign wr_row[b] = '0;
            end
        end

        for (genvar k = 0; k < USED_BUTTONS; k++)
        begin : g_button
            localparam int BIT = button_of(k);
            count_t old_count;
            count_t new_count;

            assign old_count = s1_live_reg ? count_t'(row_rdata_reg[BIT]) : '0;

            gip_button_lane u_lane (
                .old_count (old_count),
                .pressed   (s1_mask_reg[BIT]),
                .new_count (new_count)
            );

            assign wr_row[BIT]    = new_count;
            assign words[k].kind  = ITEM_BUTTON;
            assign words[k].slot  = SLOT_W'(BIT);
            assign words[k].level = {{(LEVEL_W-CNT_W){new_count[CNT_W-1]}}, new_count};
        end

        for (genvar a = 0; a < AXES; a++)
        begin : g_axis
            gip_axis_lane u_lane (
                .value    (s1_axis_reg[a]),
                .pos_zone (pos_zone_reg[a]),
                .neg_zone (neg_zone_reg[a]),
                .level    (axis_level[a])
            );

            assign words[USED_BUTTONS + a].kind  = ITEM_AXIS;
            assign words[USED_BUTTONS + a].slot  = SLOT_W'(a);
            assign words[USED_BUTTONS + a].level = axis_level[a];
        end
    endgenerate

    gip_result_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (xfer),
        .words       (words),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .item_kind   (item_kind),
        .slot        (slot),
        .level       (level),
        .last_of_run (last_of_run)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: gamepad input qualifier
// Drives poll samples through the valid/ready input and checks each result
// word against an in-bench model of the hold counters and the dead zones.
// Covers field extremes, counter release and long holds, unusual zone
// settings, ignored register writes, random idling on both sides and stalls.
// ---------------------------------------------------------------------------
module tb;
    import gip_pkg::*;

    localparam int DUT_PADS     = PAD_COUNT_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SHOWN_ERRORS = 10;
    localparam int HOLD_SAMPLES = 16;
    localparam logic [CFG_INDEX_W-1:0] FIRST_SPARE_REG = 4'd8;

    typedef struct {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        level_t            level;
        logic              last;
    } qual_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             pad_index;
    logic [BUTTON_BITS-1:0] pressed_mask;
    axis_t                  left_x;
    axis_t                  left_y;
    axis_t                  right_x;
    axis_t                  right_y;
    logic                   out_valid;
    logic                   out_ready;
    logic                   item_kind;
    logic [SLOT_W-1:0]      slot;
    level_t                 level;
    logic                   last_of_run;

    // Model state: hold counters and dead zone thresholds.
    int hold_count [DUT_PADS][BUTTON_BITS];
    int zone_pos [AXES];
    int zone_neg [AXES];
    logic [BUTTON_BITS-1:0] last_mask [4];

    qual_word_t expected_words[$];

    int errors;
    int samples_sent;
    int words_checked;
    int wraps_seen;
    int zone_writes;
    int stalled_inputs;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_left;

    gamepad_input_qualifier #(
        .PAD_COUNT(DUT_PADS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pad_index   (pad_index),
        .pressed_mask(pressed_mask),
        .left_x      (left_x),
        .left_y      (left_y),
        .right_x     (right_x),
        .right_y     (right_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .item_kind   (item_kind),
        .slot        (slot),
        .level       (level),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ----------------------------------------------------------------- model

    function automatic level_t dead_zone(input int v, input int pos, input int neg);
        int r = 0;
        if (v > pos || v < neg)
            r = (v > 0) ? v - pos : v - neg;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return level_t'(r);
    endfunction

    task automatic predict_sample(input logic [1:0] pad, input logic [BUTTON_BITS-1:0] mask,
                                  input axis_t lx, input axis_t ly,
                                  input axis_t rx, input axis_t ry);
        qual_word_t w;
        int         cnt;
        int         v [AXES];
        bit         known_pad;
        known_pad = int'(pad) < DUT_PADS;
        v[0] = int'(lx);
        v[1] = int'(ly);
        v[2] = int'(rx);
        v[3] = int'(ry);
        for (int b = 0; b < BUTTON_BITS; b++)
        begin
            if (b == SKIP_BIT_A || b == SKIP_BIT_B)
                continue;
            cnt = known_pad ? hold_count[pad][b] : 0;
            if (mask[b])
            begin
                cnt++;
                if (cnt >= HOLD_WRAP_AT)
                begin
                    cnt = HOLD_WRAP_TO;
                    wraps_seen++;
                end
            end
            else if (cnt > 0)
                cnt = -1;
            else
                cnt = 0;
            if (known_pad)
                hold_count[pad][b] = cnt;
            w.kind  = ITEM_BUTTON;
            w.slot  = SLOT_W'(b);
            w.level = level_t'(cnt);
            w.last  = 1'b0;
            expected_words.push_back(w);
        end
        for (int a = 0; a < AXES; a++)
        begin
            w.kind  = ITEM_AXIS;
            w.slot  = SLOT_W'(a);
            w.level = dead_zone(v[a], zone_pos[a], zone_neg[a]);
            w.last  = (a == AXES - 1);
            expected_words.push_back(w);
        end
    endtask

    // ------------------------------------------------------------- stimulus

    function automatic logic [CFG_INDEX_W-1:0] pos_reg(input int a);
        case (a)
            0:       return REG_LX_POS;
            1:       return REG_LY_POS;
            2:       return REG_RX_POS;
            default: return REG_RY_POS;
        endcase
    endfunction

    function automatic logic [CFG_INDEX_W-1:0] neg_reg(input int a);
        case (a)
            0:       return REG_LX_NEG;
            1:       return REG_LY_NEG;
            2:       return REG_RX_NEG;
            default: return REG_RY_NEG;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx < FIRST_SPARE_REG)
        begin
            if (idx[0] == 1'b0)
                zone_pos[idx >> 1] = int'(data & 16'h7FFF);
            else
                zone_neg[idx >> 1] = int'($signed(data));
            zone_writes++;
        end
    endtask

    task automatic set_zone(input int a, input logic [CFG_DATA_W-1:0] pos,
                            input logic [CFG_DATA_W-1:0] neg);
        write_reg(pos_reg(a), pos);
        write_reg(neg_reg(a), neg);
    endtask

    task automatic set_all_zones(input logic [CFG_DATA_W-1:0] pos,
                                 input logic [CFG_DATA_W-1:0] neg);
        for (int a = 0; a < AXES; a++)
            set_zone(a, pos, neg);
    endtask

    task automatic set_random_zones();
        logic [CFG_DATA_W-1:0] pos;
        logic [CFG_DATA_W-1:0] neg;
        for (int a = 0; a < AXES; a++)
        begin
            // Bit 15 of a positive threshold write is junk the block must drop.
            pos = CFG_DATA_W'($urandom_range(32767)) | (CFG_DATA_W'($urandom_range(1)) << 15);
            if ($urandom_range(9) == 0)
                neg = CFG_DATA_W'($urandom_range(32767));
            else
                neg = CFG_DATA_W'(-int'($urandom_range(32768)));
            set_zone(a, pos, neg);
        end
    endtask

    task automatic send_sample(input logic [1:0] pad, input logic [BUTTON_BITS-1:0] mask,
                               input axis_t lx, input axis_t ly,
                               input axis_t rx, input axis_t ry);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        pad_index    <= pad;
        pressed_mask <= mask;
        left_x       <= lx;
        left_y       <= ly;
        right_x      <= rx;
        right_y      <= ry;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_sample(pad, mask, lx, ly, rx, ry);
        samples_sent++;
    endtask

    function automatic axis_t pick_axis(input int pos, input int neg);
        int v;
        case ($urandom_range(5))
            0:       v = pos + int'($urandom_range(4)) - 2;
            1:       v = neg + int'($urandom_range(4)) - 2;
            2:       v = ($urandom_range(1) != 0) ? 32767 : -32768;
            3:       v = int'($urandom_range(64)) - 32;
            default: v = int'(axis_t'($urandom()));
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return axis_t'(v);
    endfunction

    // Mostly repeat the pad's previous mask so that counters climb; now and
    // then flip one button or throw in a fresh mask.
    function automatic logic [BUTTON_BITS-1:0] pick_mask(input int pad);
        logic [BUTTON_BITS-1:0] m;
        int r;
        int bit_no;
        r      = $urandom_range(99);
        bit_no = $urandom_range(BUTTON_BITS - 1);
        m      = last_mask[pad];
        if (r >= 88)
            m = BUTTON_BITS'($urandom());
        else if (r >= 55)
            m[bit_no] = ~m[bit_no];
        last_mask[pad] = m;
        return m;
    endfunction

    task automatic send_random_sample();
        logic [1:0] pad;
        pad = 2'($urandom_range(3));
        send_sample(pad, pick_mask(pad),
                    pick_axis(zone_pos[0], zone_neg[0]), pick_axis(zone_pos[1], zone_neg[1]),
                    pick_axis(zone_pos[2], zone_neg[2]), pick_axis(zone_pos[3], zone_neg[3]));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ----------------------------------------------------------------- tests

    task automatic test_directed();
        send_sample(2'd0, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(2'd0, 16'hFFFF, 16'sd32767, -16'sd32768, 16'sd7849, -16'sd7849);
        // Release of every button, axes one step outside each zone.
        send_sample(2'd0, 16'h0000, 16'sd7850, -16'sd7850, 16'sd8690, -16'sd8690);
        // Press right after release only brings the counter back to zero.
        send_sample(2'd0, 16'hFFFF, 16'sd7848, -16'sd7848, 16'sd8689, -16'sd8689);
        send_sample(2'd0, 16'hFFFF, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768);
        send_sample(2'd0, 16'hF3FF, 16'sd7849, 16'sd7850, -16'sd8690, 16'sd8689);
        send_sample(2'd1, 16'h0C00, -16'sd32768, 16'sd32767, 16'sd0, -16'sd1);
        send_sample(2'd1, 16'h5555, 16'sh5555, -16'sh5556, 16'sh2AAA, -16'sh2AAB);
        send_sample(2'd1, 16'hAAAA, -16'sh5556, 16'sh5555, -16'sh2AAB, 16'sh2AAA);
        send_sample(2'd1, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(2'd2, 16'h8001, 16'sd12345, -16'sd12345, 16'sd20000, -16'sd20000);
        send_sample(2'd2, 16'hFFFF, -16'sd32767, 16'sd32766, 16'sd1, -16'sd2);
        send_sample(2'd3, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(2'd3, 16'h0C00, 16'sd8000, -16'sd8000, 16'sd9000, -16'sd9000);
        send_sample(2'd3, 16'h0000, 16'sd100, -16'sd100, 16'sd100, -16'sd100);
        wait_idle();
    endtask

    task automatic test_zone_settings();
        // No dead zone at all: every value passes unchanged.
        set_all_zones(16'd0, 16'd0);
        send_sample(2'd0, 16'h0001, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768);
        repeat (3) send_random_sample();
        wait_idle();

        // Widest zones: nothing gets out.
        set_all_zones(16'd32767, 16'h8000);
        send_sample(2'd1, 16'h0002, 16'sd32767, -16'sd32768, 16'sd32766, -16'sd32767);
        repeat (3) send_random_sample();
        wait_idle();

        // Negative threshold above zero; large negative levels saturate.
        set_all_zones(16'd0, 16'd32767);
        send_sample(2'd2, 16'h0004, -16'sd32768, 16'sd5, 16'sd0, -16'sd1);
        send_sample(2'd2, 16'h0004, 16'sd32767, -16'sd2, 16'sd32766, 16'sd1);
        wait_idle();
        set_all_zones(16'd50, 16'd100);
        send_sample(2'd3, 16'h0008, 16'sd70, 16'sd30, 16'sd50, 16'sd100);
        send_sample(2'd3, 16'h0008, 16'sd101, -16'sd1, 16'sd49, 16'sd0);
        wait_idle();

        // Positive threshold write with bit 15 set keeps only the low bits.
        set_all_zones(16'hFFFF, 16'hFFFF);
        send_sample(2'd0, 16'h0010, 16'sd32767, -16'sd32768, -16'sd1, -16'sd2);
        repeat (2) send_random_sample();
        wait_idle();

        // Writes above the last register must change nothing.
        for (int k = 0; k < 8; k++)
            write_reg(FIRST_SPARE_REG + CFG_INDEX_W'(k), CFG_DATA_W'($urandom()));
        send_sample(2'd1, 16'h0020, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768);
        repeat (3) send_random_sample();
        wait_idle();

        set_zone(0, CFG_DATA_W'(LEFT_POS_RST), LEFT_NEG_RST);
        set_zone(1, CFG_DATA_W'(LEFT_POS_RST), LEFT_NEG_RST);
        set_zone(2, CFG_DATA_W'(RIGHT_POS_RST), RIGHT_NEG_RST);
        set_zone(3, CFG_DATA_W'(RIGHT_POS_RST), RIGHT_NEG_RST);
        repeat (4) send_random_sample();
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int send_modes [4];
        int recv_modes [4];
        send_modes = '{0, 79, 0, 9};
        recv_modes = '{0, 0, 79, 9};
        for (int p = 0; p < 4; p++)
        begin
            set_random_zones();
            send_idle_pct  = send_modes[p];
            recv_stall_pct = recv_modes[p];
            repeat (50) send_random_sample();
            wait_idle();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_input_stall();
        set_random_zones();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 300;
        repeat (16) send_random_sample();
        wait_idle();
    endtask

    task automatic test_steady_hold();
        logic [BUTTON_BITS-1:0] mask;
        // A steady hold on one pad makes its counters climb sample by sample.
        repeat (HOLD_SAMPLES)
        begin
            mask = {4'hF, 2'($urandom()), 10'h3FF};
            send_sample(2'd3, mask,
                        pick_axis(zone_pos[0], zone_neg[0]), pick_axis(zone_pos[1], zone_neg[1]),
                        pick_axis(zone_pos[2], zone_neg[2]), pick_axis(zone_pos[3], zone_neg[3]));
        end
        send_sample(2'd3, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        wait_idle();
    endtask

    // -------------------------------------------------------------- checking

    task automatic note_error(input string msg);
        errors++;
        if (errors <= SHOWN_ERRORS)
            $display("%0t: %s", $realtime, msg);
    endtask

    initial
    begin : check_words
        qual_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && in_valid && !in_ready)
                stalled_inputs++;
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    note_error($sformatf("unexpected word kind %0d slot %0d level %0d last %0d",
                                         item_kind, slot, level, last_of_run));
                else
                begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (item_kind !== want.kind || slot !== want.slot ||
                        level !== want.level || last_of_run !== want.last)
                        note_error($sformatf(
                            "word mismatch: expected kind %0d slot %0d level %0d last %0d, got kind %0d slot %0d level %0d last %0d",
                            want.kind, want.slot, want.level, want.last,
                            item_kind, slot, level, last_of_run));
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        pad_index      = '0;
        pressed_mask   = '0;
        left_x         = '0;
        left_y         = '0;
        right_x        = '0;
        right_y        = '0;
        out_ready      = 1'b0;
        errors         = 0;
        samples_sent   = 0;
        words_checked  = 0;
        wraps_seen     = 0;
        zone_writes    = 0;
        stalled_inputs = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 0;
        for (int p = 0; p < DUT_PADS; p++)
            for (int b = 0; b < BUTTON_BITS; b++)
                hold_count[p][b] = 0;
        for (int p = 0; p < 4; p++)
            last_mask[p] = '0;
        zone_pos[0] = int'(LEFT_POS_RST);
        zone_pos[1] = int'(LEFT_POS_RST);
        zone_pos[2] = int'(RIGHT_POS_RST);
        zone_pos[3] = int'(RIGHT_POS_RST);
        zone_neg[0] = int'(LEFT_NEG_RST);
        zone_neg[1] = int'(LEFT_NEG_RST);
        zone_neg[2] = int'(RIGHT_NEG_RST);
        zone_neg[3] = int'(RIGHT_NEG_RST);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(posedge clk);

        test_directed();
        test_zone_settings();
        test_random_traffic();
        test_input_stall();
        test_steady_hold();

        $display("Checked %0d words from %0d samples; %0d zone writes, %0d counter wraps,",
                 words_checked, samples_sent, zone_writes, wraps_seen);
        $display("%0d cycles with the input held back by a full block.", stalled_inputs);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
